[rtl/core/rsi_pkg.sv]
package rsi_pkg;

  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned RSI_W      = 15;

  // gain/loss in fixed point, sums over up to 2^PERIOD_W deltas, product by n-1
  localparam int unsigned X_W    = PRICE_BITS + FRAC_BITS;
  localparam int unsigned AVG_W  = X_W + PERIOD_W;
  localparam int unsigned WIDE_W = AVG_W + PERIOD_W;
  localparam int unsigned DEN_W  = AVG_W + 1;
  localparam int unsigned PROD_W = AVG_W + RSI_W;
  localparam int unsigned STEP_W = $clog2(WIDE_W + 1);

  localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(25600);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem_init;
    logic [WIDE_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/rsi_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// The dividend register shifts left and collects quotient bits at the bottom;
// after k steps its low k bits hold the quotient.
module rsi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsi_pkg::div_req_t req_i,
  output rsi_pkg::div_rsp_t rsp_o
);

  localparam logic [rsi_pkg::STEP_W-1:0] STEP_ONE = rsi_pkg::STEP_W'(1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [rsi_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  logic [rsi_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [rsi_pkg::WIDE_W-1:0]    num_q, num_d;
  logic [rsi_pkg::DEN_W-1:0]     den_q, den_d;

  logic [rsi_pkg::DEN_W:0]       trial;
  logic [rsi_pkg::DEN_W:0]       diff;
  logic                          fits;

  assign trial = {rem_q, num_q[rsi_pkg::WIDE_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? diff[rsi_pkg::DEN_W-1:0] : trial[rsi_pkg::DEN_W-1:0];
      num_d = {num_q[rsi_pkg::WIDE_W-2:0], fits};
      cnt_d = cnt_q - STEP_ONE;
      if (cnt_q == STEP_ONE) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

[rtl/core/relative_strength_index_top.sv]
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_ready_o, price_i, restart_i | sink
// out      | out_valid_o, out_ready_i, rsi_value_o,     | source
//          | rsi_valid_o                                |
// config   | cfg_we_i, cfg_data_i (period)              | sink
//
// Restart or first price: delta, then done. Warm-up without result: delta,
// sum, then done. Both averages and the ratio use the shared radix-2 divider
// (64 steps per average, 15 for the ratio, which zero average loss skips).
// Reset is asynchronous; no clearing pass. in_ready_o is high only when idle;
// a finished result waits in the output register while the next item is taken.
module relative_strength_index_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsi_pkg::PERIOD_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    price_i,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rsi_pkg::RSI_W-1:0]      rsi_value_o,
  output logic                           rsi_valid_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_SUM,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_RATIO,
    S_RSTART,
    S_RWAIT,
    S_DONE
  } state_e;

  state_e                             state_q;
  logic [rsi_pkg::PERIOD_W-1:0]       period_q;
  logic [rsi_pkg::PERIOD_W-1:0]       n_q;
  logic [rsi_pkg::PRICE_BITS-1:0]     price_q;
  logic                               restart_q;
  logic [rsi_pkg::PRICE_BITS-1:0]     last_q;
  logic                               have_prev_q;
  logic [rsi_pkg::PERIOD_W-1:0]       count_q;
  logic                               warm_q;
  logic                               smooth_q;
  logic                               side_q;
  logic [rsi_pkg::AVG_W-1:0]          gain_q;
  logic [rsi_pkg::AVG_W-1:0]          loss_q;
  logic [rsi_pkg::X_W-1:0]            xg_q;
  logic [rsi_pkg::X_W-1:0]            xl_q;
  logic [rsi_pkg::WIDE_W-1:0]         prod_q;
  logic [rsi_pkg::PROD_W-1:0]         rat_q;
  logic [rsi_pkg::DEN_W-1:0]          den_q;
  logic [rsi_pkg::RSI_W-1:0]          res_value_q;
  logic                               res_valid_q;
  logic                               out_valid_q;
  logic [rsi_pkg::RSI_W-1:0]          out_value_q;
  logic                               out_flag_q;

  logic                               in_fire;
  logic                               out_load;
  logic [rsi_pkg::PRICE_BITS-1:0]     up_diff;
  logic [rsi_pkg::PRICE_BITS-1:0]     dn_diff;
  logic                               price_up;
  logic [rsi_pkg::PERIOD_W-1:0]       cnt_nx;
  logic [rsi_pkg::AVG_W-1:0]          side_avg;
  logic [rsi_pkg::X_W-1:0]            side_x;
  logic [rsi_pkg::PERIOD_W-1:0]       factor;
  logic [rsi_pkg::WIDE_W-1:0]         addend;
  rsi_pkg::div_req_t                  div_req;
  rsi_pkg::div_rsp_t                  div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign price_up = price_q > last_q;
  assign up_diff  = price_q - last_q;
  assign dn_diff  = last_q - price_q;
  assign cnt_nx   = count_q + rsi_pkg::PERIOD_W'(1);

  assign side_avg = side_q ? loss_q : gain_q;
  assign side_x   = side_q ? xl_q : xg_q;
  // seeding divides the raw sum: multiply by one, add nothing
  assign factor   = smooth_q ? (n_q - rsi_pkg::PERIOD_W'(1)) : rsi_pkg::PERIOD_W'(1);
  assign addend   = smooth_q ? rsi_pkg::WIDE_W'(side_x) : '0;

  always_comb begin
    div_req       = '0;
    div_req.start = (state_q == S_DSTART) || (state_q == S_RSTART);
    if (state_q == S_RSTART) begin
      div_req.rem_init = rsi_pkg::DEN_W'(rat_q[rsi_pkg::PROD_W-1:rsi_pkg::RSI_W]);
      div_req.num      = {rat_q[rsi_pkg::RSI_W-1:0], (rsi_pkg::WIDE_W-rsi_pkg::RSI_W)'(0)};
      div_req.den      = den_q;
      div_req.steps    = rsi_pkg::STEP_W'(rsi_pkg::RSI_W);
    end else begin
      div_req.rem_init = '0;
      div_req.num      = prod_q + addend;
      div_req.den      = rsi_pkg::DEN_W'(n_q);
      div_req.steps    = rsi_pkg::STEP_W'(rsi_pkg::WIDE_W);
    end
  end

  rsi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= rsi_pkg::PERIOD_RESET;
      n_q         <= rsi_pkg::PERIOD_RESET;
      price_q     <= '0;
      restart_q   <= 1'b0;
      last_q      <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      warm_q      <= 1'b0;
      smooth_q    <= 1'b0;
      side_q      <= 1'b0;
      gain_q      <= '0;
      loss_q      <= '0;
      xg_q        <= '0;
      xl_q        <= '0;
      prod_q      <= '0;
      rat_q       <= '0;
      den_q       <= '0;
      res_value_q <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            price_q   <= price_i[rsi_pkg::PRICE_BITS-1:0];
            restart_q <= restart_i;
            n_q       <= (period_q == '0) ? rsi_pkg::PERIOD_W'(1) : period_q;
            state_q   <= S_DELTA;
          end
        end
        S_DELTA: begin
          last_q <= price_q;
          if (restart_q || !have_prev_q) begin
            have_prev_q <= 1'b1;
            count_q     <= '0;
            warm_q      <= 1'b0;
            gain_q      <= '0;
            loss_q      <= '0;
            res_value_q <= '0;
            res_valid_q <= 1'b0;
            state_q     <= S_DONE;
          end else begin
            xg_q     <= price_up ? {up_diff, rsi_pkg::FRAC_BITS'(0)} : '0;
            xl_q     <= price_up ? '0 : {dn_diff, rsi_pkg::FRAC_BITS'(0)};
            smooth_q <= warm_q;
            side_q   <= 1'b0;
            state_q  <= warm_q ? S_MUL : S_SUM;
          end
        end
        S_SUM: begin
          gain_q <= gain_q + rsi_pkg::AVG_W'(xg_q);
          loss_q <= loss_q + rsi_pkg::AVG_W'(xl_q);
          if (cnt_nx >= n_q) begin
            warm_q  <= 1'b1;
            count_q <= '0;
            state_q <= S_MUL;
          end else begin
            count_q     <= cnt_nx;
            res_value_q <= '0;
            res_valid_q <= 1'b0;
            state_q     <= S_DONE;
          end
        end
        S_MUL: begin
          prod_q  <= rsi_pkg::WIDE_W'(side_avg) * rsi_pkg::WIDE_W'(factor);
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            if (side_q) begin
              loss_q  <= div_rsp.quot[rsi_pkg::AVG_W-1:0];
              state_q <= S_RATIO;
            end else begin
              gain_q  <= div_rsp.quot[rsi_pkg::AVG_W-1:0];
              side_q  <= 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_RATIO: begin
          res_valid_q <= 1'b1;
          if (loss_q == '0) begin
            res_value_q <= rsi_pkg::RSI_FULL;
            state_q     <= S_DONE;
          end else begin
            den_q   <= rsi_pkg::DEN_W'(gain_q) + rsi_pkg::DEN_W'(loss_q);
            rat_q   <= rsi_pkg::PROD_W'(gain_q) * rsi_pkg::PROD_W'(rsi_pkg::RSI_FULL);
            state_q <= S_RSTART;
          end
        end
        S_RSTART: begin
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            res_value_q <= div_rsp.quot[rsi_pkg::RSI_W-1:0];
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          // hold here until the output register is free
          if (out_load) begin
            out_value_q <= res_value_q;
            out_flag_q  <= res_valid_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsi_value_o = out_value_q;
  assign rsi_valid_o = out_flag_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DWAIT || state_q == S_RWAIT))
    else $error("divider finished outside a wait state");

  a_wait_has_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT || state_q == S_RWAIT) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rsi_valid_o) |-> (rsi_value_o == '0))
    else $error("invalid result with nonzero value");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rsi_value_o <= rsi_pkg::RSI_FULL))
    else $error("rsi value above full scale");

endmodule

[tb/sv/tb_relative_strength_index_top.sv]
`timescale 1ns / 100ps

class rsi_scoreboard;
  localparam logic [8:0] WARM_DONE = 9'h100;

  typedef struct {
    logic [rsi_pkg::RSI_W-1:0] value;
    logic                      valid;
  } rsi_result_t;

  rsi_result_t expected_rsi[$];

  // predictor state
  logic [7:0]  period;
  logic [31:0] last_price;
  logic [8:0]  delta_count;
  logic [63:0] gain_avg;
  logic [63:0] loss_avg;
  logic        have_previous;

  int errors;
  int checked;
  int accepted;
  int restarts;
  int valid_seen;
  int period_writes;

  function new();
    period        = rsi_pkg::PERIOD_RESET;
    last_price    = '0;
    delta_count   = '0;
    gain_avg      = '0;
    loss_avg      = '0;
    have_previous = 1'b0;
  endfunction

  function void set_period(logic [7:0] p);
    period = p;
    period_writes++;
  endfunction

  function int pending();
    return expected_rsi.size();
  endfunction

  function void note_price(logic [31:0] price, logic restart);
    logic [63:0]  n;
    logic [63:0]  gain;
    logic [63:0]  loss;
    logic [63:0]  total;
    logic [127:0] scaled;
    rsi_result_t  r;
    n       = (period == 8'd0) ? 64'd1 : {56'd0, period};
    gain    = '0;
    loss    = '0;
    r.value = '0;
    r.valid = 1'b0;
    accepted++;
    if (restart) restarts++;
    if (restart || !have_previous) begin
      last_price    = price;
      have_previous = 1'b1;
      delta_count   = '0;
      gain_avg      = '0;
      loss_avg      = '0;
    end else begin
      if (price > last_price) begin
        gain = ({32'd0, price} - {32'd0, last_price}) << rsi_pkg::FRAC_BITS;
      end else begin
        loss = ({32'd0, last_price} - {32'd0, price}) << rsi_pkg::FRAC_BITS;
      end
      last_price = price;
      if (!delta_count[8]) begin
        // warm-up: averages hold running sums until n deltas are in
        gain_avg    = gain_avg + gain;
        loss_avg    = loss_avg + loss;
        delta_count = {1'b0, delta_count[7:0] + 8'd1};
        if ({55'd0, delta_count} >= n) begin
          gain_avg    = gain_avg / n;
          loss_avg    = loss_avg / n;
          delta_count = WARM_DONE;
          r.valid     = 1'b1;
        end
      end else begin
        gain_avg = (gain_avg * (n - 64'd1) + gain) / n;
        loss_avg = (loss_avg * (n - 64'd1) + loss) / n;
        r.valid  = 1'b1;
      end
      if (r.valid) begin
        total = gain_avg + loss_avg;
        if (loss_avg == 64'd0 || total < gain_avg) begin
          r.value = rsi_pkg::RSI_FULL;
        end else begin
          scaled  = ({64'd0, gain_avg} * {113'd0, rsi_pkg::RSI_FULL}) / {64'd0, total};
          r.value = scaled[rsi_pkg::RSI_W-1:0];
        end
      end
    end
    expected_rsi.push_back(r);
  endfunction

  task report_mismatch(string what, int got, int want);
    if (errors < 40) begin
      $display("MISMATCH %s at result %0d: got %0d, expected %0d", what, checked, got, want);
    end
    errors++;
  endtask

  task check_rsi(logic [rsi_pkg::RSI_W-1:0] value, logic valid);
    rsi_result_t want;
    checked++;
    if (expected_rsi.size() == 0) begin
      report_mismatch("unexpected transaction", value, 0);
    end else begin
      want = expected_rsi.pop_front();
      if (value !== want.value) report_mismatch("rsi_value", value, want.value);
      if (valid !== want.valid) report_mismatch("rsi_valid", valid, want.valid);
      if (want.valid) valid_seen++;
    end
  endtask
endclass

module tb_relative_strength_index_top;

  typedef enum int {
    WALK_SMALL,
    WALK_WIDE,
    TREND_UP,
    TREND_DOWN,
    FLAT_LINE,
    NOISE
  } price_mode_e;

  localparam int DIRECTED_SPLIT = 16;
  localparam logic [31:0] DIRECTED_PRICE [25] = '{
    32'd100, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'd1000, 32'd1200, 32'd1100, 32'd1100, 32'd5,
    32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
    32'h7FFF_FF00,
    32'd5, 32'd6, 32'd7, 32'd7, 32'd10, 32'd10, 32'd10, 32'd9, 32'hFFFF_FFFF
  };
  localparam bit DIRECTED_RESTART [25] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [rsi_pkg::PERIOD_W-1:0]  cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [31:0]                   price_i     = '0;
  logic                          restart_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [rsi_pkg::RSI_W-1:0]     rsi_value_o;
  logic                          rsi_valid_o;

  rsi_scoreboard sb;

  int          burst_left = 0;
  int          mode_left  = 0;
  price_mode_e series_mode = WALK_SMALL;
  logic [31:0] cur_price  = '0;
  bit          long_hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  relative_strength_index_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .price_i     (price_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsi_value_o (rsi_value_o),
    .rsi_valid_o (rsi_valid_o)
  );

  // transaction monitor: config, accepted prices, accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_period(cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_price(price_i, restart_i);
      if (out_valid_o && out_ready_i) sb.check_rsi(rsi_value_o, rsi_valid_o);
    end
  end

  // receiver: stall pattern changes every so often; one long hold-off
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && sb.checked >= 500) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready_i <= ($urandom_range(0, 7) == 0);
          end
          default: begin
            out_ready_i <= left[3];
          end
        endcase
      end
    end
  end

  initial begin
    #30_000_000;
    $display("relative_strength_index_top test failed");
    $finish;
  end

  task automatic drive_price(input logic [31:0] price, input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    price_i    <= price;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // one edge first so the monitor has logged the last accepted price
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_period(input int p);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= 8'(p);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] next_price();
    if (mode_left == 0) begin
      series_mode = price_mode_e'($urandom_range(0, 5));
      mode_left   = $urandom_range(8, 40);
    end
    mode_left--;
    if ($urandom_range(0, 49) == 0) begin
      cur_price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      return cur_price;
    end
    if ($urandom_range(0, 19) == 0) begin
      cur_price = $urandom;
      return cur_price;
    end
    case (series_mode)
      WALK_SMALL: cur_price = cur_price + 32'($urandom_range(0, 510)) - 32'd255;
      WALK_WIDE:  cur_price = cur_price + 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
      TREND_UP:   cur_price = cur_price + 32'($urandom_range(0, 4095));
      TREND_DOWN: cur_price = cur_price - 32'($urandom_range(0, 4095));
      FLAT_LINE: begin
        if ($urandom_range(0, 7) == 0) cur_price = cur_price + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default:    cur_price = $urandom;
    endcase
    return cur_price;
  endfunction

  task automatic run_phase(input int p, input int items, input bit fresh, input int restart_odds);
    bit restart;
    write_period(p);
    for (int i = 0; i < items; i++) begin
      restart = (i == 0 && fresh) ||
                (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
      if (restart) begin
        mode_left = 0;
        cur_price = $urandom;
      end
      drive_price(next_price(), restart);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset period first, then a short period for the corner cases
    for (int i = 0; i < DIRECTED_SPLIT; i++) begin
      drive_price(DIRECTED_PRICE[i], DIRECTED_RESTART[i]);
    end
    write_period(2);
    for (int i = DIRECTED_SPLIT; i < 25; i++) begin
      drive_price(DIRECTED_PRICE[i], DIRECTED_RESTART[i]);
    end

    run_phase(1, 200, 1'b1, 40);
    run_phase(255, 150, 1'b1, 0);
    // warm-up count already past the new period: seeds on the next delta
    run_phase(20, 150, 1'b0, 0);
    run_phase(0, 150, 1'b1, 50);
    run_phase(2, 200, 1'b1, 30);
    run_phase(255, 300, 1'b1, 0);
    repeat (4) run_phase($urandom_range(3, 40), 150, 1'(($urandom_range(0, 1))), 80);
    run_phase(60, 100, 1'b1, 0);
    // smoothing continues under a different period
    run_phase(3, 50, 1'b0, 0);

    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("Covered %0d prices with %0d restarts; %0d results checked, %0d past warm-up.",
             sb.accepted, sb.restarts, sb.checked, sb.valid_seen);
    $display("Period written %0d times (0, 1, 2, 255 and random), one long output stall.",
             sb.period_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("relative_strength_index_top test passed");
    end else begin
      $display("relative_strength_index_top test failed");
    end
    $finish;
  end

endmodule
